FILE: sv/plp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plp_pkg: shared constants for the point-to-line projection block
// Fraction width, result width and queue depths used by the back and the
// top level.
// ----------------------------------------------------------------------------
package plp_pkg;

  // fractional bits of the line parameter (Q16.16)
  localparam int FRAC_BITS   = 16;
  // bits of the quotient and of the root, one pipeline stage each
  localparam int RES_BITS    = 32;
  // queue between front and back, and result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 2;

endpackage

FILE: sv/plp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plp_fifo: small synchronous queue
// Register array with write and read pointers and an occupancy count.
// ----------------------------------------------------------------------------
module plp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH))
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not advance on push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    do_pop && !do_push |=> count == $past(count) - 1'b1)
    else $error("queue count did not drop on pop");
`endif

endmodule

FILE: sv/plp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plp_front: difference vectors, products and sums
// Three stages: a-relative vectors, six products, then |b-a|^2, the dot
// product as sign and magnitude, and the magnitude of the cross product.
// ----------------------------------------------------------------------------
module plp_front #(
  parameter int C = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic signed [C-1:0]  point_x,
  input  logic signed [C-1:0]  point_y,
  input  logic signed [C-1:0]  start_x,
  input  logic signed [C-1:0]  start_y,
  input  logic signed [C-1:0]  end_x,
  input  logic signed [C-1:0]  end_y,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2*C+1:0]       len2,
  output logic                 dot_neg,
  output logic [2*C+1:0]       dot_mag,
  output logic [2*C+1:0]       cross_mag
);

  localparam int DW = C + 1;
  localparam int W  = 2 * C + 2;

  logic                 v0, v1, v2;
  logic                 en;
  logic signed [DW-1:0] dx, dy, vx, vy;
  logic signed [W-1:0]  pxx, pyy, pxv, pyv, pxw, pyw;
  logic signed [W-1:0]  sum_l, dotv, crossv;

  assign en        = !v2 || out_ready;
  assign full      = !en;
  assign out_valid = v2;

  assign sum_l  = pxx + pyy;
  assign dotv   = pxv + pyv;
  assign crossv = pxw - pyw;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v0 <= push;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx <= DW'(end_x) - DW'(start_x);
      dy <= DW'(end_y) - DW'(start_y);
      vx <= DW'(point_x) - DW'(start_x);
      vy <= DW'(point_y) - DW'(start_y);
      pxx <= dx * dx;
      pyy <= dy * dy;
      pxv <= dx * vx;
      pyv <= dy * vy;
      pxw <= dx * vy;
      pyw <= dy * vx;
      len2      <= sum_l;
      dot_neg   <= dotv[W-1];
      dot_mag   <= dotv[W-1] ? W'(-dotv) : dotv;
      cross_mag <= crossv[W-1] ? W'(-crossv) : crossv;
    end
  end

endmodule

FILE: sv/plp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plp_back: parameter division and distance root
// A setup stage squares the cross magnitude in partial products, then one
// stage per result bit runs a restoring division for t and a bitwise root
// search for the distance side by side.
// ----------------------------------------------------------------------------
module plp_back
  import plp_pkg::*;
#(
  parameter int C = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [2*C+1:0] len2,
  input  logic           dot_neg,
  input  logic [2*C+1:0] dot_mag,
  input  logic [2*C+1:0] cross_mag,
  output logic           res_valid,
  input  logic           res_ready,
  output logic [31:0]    line_param,
  output logic [31:0]    perp_distance,
  output logic           param_saturated,
  output logic           degenerate
);

  localparam int W  = 2 * C + 2;
  localparam int H  = W / 2;
  localparam int N  = RES_BITS;
  localparam int RW = W + 1;
  localparam int SW = 2 * N + W + 2;
  localparam int PW = W + N + 1;

  logic en;

  // setup stage
  logic                 b_v, b_neg, b_sat, b_deg;
  logic [W-1:0]         b_len2;
  logic [RW-1:0]        b_rem;
  logic [FRAC_BITS-1:0] b_lo;
  logic [2*H-1:0]       b_hh, b_hl, b_ll;

  // bit stages
  logic                 p_v    [N+1];
  logic                 p_neg  [N+1];
  logic                 p_sat  [N+1];
  logic                 p_deg  [N+1];
  logic [W-1:0]         p_len2 [N+1];
  logic [RW-1:0]        p_rem  [N+1];
  logic [FRAC_BITS-1:0] p_lo   [N+1];
  logic [N-1:0]         p_q    [N+1];
  logic [SW-1:0]        p_t    [N+1];
  logic [PW-1:0]        p_p    [N+1];
  logic [N-1:0]         p_r    [N+1];

  logic [RW-1:0]        rem_next [N];
  logic [N-1:0]         q_next   [N];
  logic [SW-1:0]        t_next   [N];
  logic [PW-1:0]        p_next   [N];
  logic [N-1:0]         r_next   [N];
  logic [RW-1:0]        sh       [N];
  logic [SW-1:0]        diff     [N];

  logic [SW-1:0]        x_init;
  logic [N:0]           mag;
  logic [N:0]           half;

  assign en        = !p_v[N] || res_ready;
  assign in_ready  = en;
  assign res_valid = p_v[N];

  assign x_init = ((SW'(b_hh) << (2 * H)) + (SW'(b_hl) << (H + 1)) + SW'(b_ll))
                  << FRAC_BITS;

  always_comb begin
    for (int k = 0; k < N; k++) begin
      sh[k] = {p_rem[k][RW-2:0], p_lo[k][FRAC_BITS-1]};
      if (sh[k] >= RW'(p_len2[k])) begin
        rem_next[k] = sh[k] - RW'(p_len2[k]);
        q_next[k]   = {p_q[k][N-2:0], 1'b1};
      end else begin
        rem_next[k] = sh[k];
        q_next[k]   = {p_q[k][N-2:0], 1'b0};
      end
      // try the next root bit: (r+2^i)^2*L - r^2*L = (r*L << i+1) + (L << 2i)
      diff[k] = (SW'(p_p[k]) << (N - k)) + (SW'(p_len2[k]) << (2 * (N - 1 - k)));
      if (diff[k] <= p_t[k]) begin
        t_next[k] = p_t[k] - diff[k];
        p_next[k] = p_p[k] + (PW'(p_len2[k]) << (N - 1 - k));
        r_next[k] = p_r[k] | (N'(1) << (N - 1 - k));
      end else begin
        t_next[k] = p_t[k];
        p_next[k] = p_p[k];
        r_next[k] = p_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
      for (int k = 0; k <= N; k++) begin
        p_v[k] <= 1'b0;
      end
    end else if (en) begin
      b_v    <= in_valid;
      p_v[0] <= b_v;
      for (int k = 0; k < N; k++) begin
        p_v[k+1] <= p_v[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_len2 <= len2;
      b_neg  <= dot_neg;
      b_deg  <= (len2 == '0);
      b_sat  <= ((dot_mag >> FRAC_BITS) >= len2);
      b_rem  <= RW'(dot_mag >> FRAC_BITS);
      b_lo   <= dot_mag[FRAC_BITS-1:0];
      b_hh   <= cross_mag[W-1:H] * cross_mag[W-1:H];
      b_hl   <= cross_mag[W-1:H] * cross_mag[H-1:0];
      b_ll   <= cross_mag[H-1:0] * cross_mag[H-1:0];

      p_len2[0] <= b_len2;
      p_neg[0]  <= b_neg;
      p_deg[0]  <= b_deg;
      p_sat[0]  <= b_sat;
      p_rem[0]  <= b_rem;
      p_lo[0]   <= b_lo;
      p_q[0]    <= '0;
      p_t[0]    <= x_init;
      p_p[0]    <= '0;
      p_r[0]    <= '0;

      for (int k = 0; k < N; k++) begin
        p_len2[k+1] <= p_len2[k];
        p_neg[k+1]  <= p_neg[k];
        p_deg[k+1]  <= p_deg[k];
        p_sat[k+1]  <= p_sat[k];
        p_rem[k+1]  <= rem_next[k];
        p_lo[k+1]   <= p_lo[k] << 1;
        p_q[k+1]    <= q_next[k];
        p_t[k+1]    <= t_next[k];
        p_p[k+1]    <= p_next[k];
        p_r[k+1]    <= r_next[k];
      end
    end
  end

  // clamp the magnitude to the Q16.16 range and apply the sign; a degenerate line gives zero
  always_comb begin
    half            = {2'b01, {(N-1){1'b0}}};
    mag             = p_sat[N] ? {1'b1, {N{1'b0}}} : {1'b0, p_q[N]};
    line_param      = '0;
    param_saturated = 1'b0;
    if (p_deg[N]) begin
      line_param      = '0;
      param_saturated = 1'b0;
    end else if (p_neg[N]) begin
      if (mag > half) begin
        line_param      = {1'b1, {(N-1){1'b0}}};
        param_saturated = 1'b1;
      end else begin
        line_param = N'((N+1)'(0) - mag);
      end
    end else begin
      if (mag >= half) begin
        line_param      = {1'b0, {(N-1){1'b1}}};
        param_saturated = 1'b1;
      end else begin
        line_param = mag[N-1:0];
      end
    end
    perp_distance = p_deg[N] ? '0 : p_r[N];
    degenerate    = p_deg[N];
  end

`ifndef SYNTHESIS
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    p_v[N] && !res_ready |=> p_v[N] && $stable(p_r[N]) && $stable(p_q[N]))
    else $error("stalled result changed");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    p_v[N] && p_deg[N] |-> line_param == '0 && perp_distance == '0)
    else $error("degenerate line with nonzero outputs");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    p_v[N] && param_saturated && !p_neg[N] |-> line_param == {1'b0, {(N-1){1'b1}}})
    else $error("positive saturation value wrong");
`endif

endmodule

FILE: sv/point_line_projection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_line_projection: foot point parameter and distance of a 2-D point
// Computes t = dot(p-a, b-a) / |b-a|^2 in Q16.16 and the perpendicular
// distance with 8 fractional bits, with degenerate and saturation flags.
//
//   channel  handshake      payload
//   input    push / full    point_x point_y start_x start_y end_x end_y
//   result   pop / empty    line_param perp_distance param_saturated degenerate
//
// One item is accepted per cycle while full is low; throughput is one result
// per cycle while the result queue is popped and nothing stalls. A result
// passes through 3 front stages, the front/back queue, a setup stage, a load
// stage plus one stage per result bit (32) shared by the divider and the root,
// and the result queue before it shows on the result ports.
// Reset clears all valid bits and queue pointers; payload is not reset.
// A full result queue stalls the back; the front keeps taking items until
// the front/back queue is full and the front's last stage holds an item.
// ----------------------------------------------------------------------------
module point_line_projection
  import plp_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [31:0]           line_param,
  output logic [31:0]                  perp_distance,
  output logic                         param_saturated,
  output logic                         degenerate
);

  localparam int W  = 2 * COORD_BITS + 2;
  localparam int QW = 3 * W + 1;
  localparam int OW = 66;

  logic          f_valid, f_ready;
  logic [W-1:0]  f_len2, f_dmag, f_cmag;
  logic          f_neg;
  logic          q_full, q_empty, q_pop;
  logic [QW-1:0] q_rdata;
  logic          b_ready, r_valid, o_full;
  logic [31:0]   r_param, r_dist;
  logic          r_sat, r_deg;
  logic [OW-1:0] o_rdata;

  plp_front #(.C(COORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .point_x   (point_x),
    .point_y   (point_y),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .len2      (f_len2),
    .dot_neg   (f_neg),
    .dot_mag   (f_dmag),
    .cross_mag (f_cmag)
  );

  assign f_ready = !q_full;

  plp_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_valid),
    .wdata ({f_len2, f_neg, f_dmag, f_cmag}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign q_pop = b_ready && !q_empty;

  plp_back #(.C(COORD_BITS)) u_back (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (!q_empty),
    .in_ready        (b_ready),
    .len2            (q_rdata[QW-1 -: W]),
    .dot_neg         (q_rdata[2*W]),
    .dot_mag         (q_rdata[2*W-1 -: W]),
    .cross_mag       (q_rdata[W-1:0]),
    .res_valid       (r_valid),
    .res_ready       (!o_full),
    .line_param      (r_param),
    .perp_distance   (r_dist),
    .param_saturated (r_sat),
    .degenerate      (r_deg)
  );

  plp_fifo #(.WIDTH(OW), .DEPTH(OUT_DEPTH)) u_out (
    .clk   (clk),
    .rst   (rst),
    .push  (r_valid),
    .wdata ({r_param, r_dist, r_sat, r_deg}),
    .full  (o_full),
    .pop   (pop),
    .rdata (o_rdata),
    .empty (empty)
  );

  assign line_param      = o_rdata[65:34];
  assign perp_distance   = o_rdata[33:2];
  assign param_saturated = o_rdata[1];
  assign degenerate      = o_rdata[0];

endmodule
